### src/gcpt_pkg.sv
package gcpt_pkg;

    localparam int DATA_W     = 16;
    localparam int IDX_W      = 10;
    localparam int LEVEL_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_BITS   = 2 * DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPANSION = 2'd1;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 13'd256;

    typedef struct packed {
        logic                     first_sweep;
        logic [IDX_W-1:0]         freq_index;
        logic signed [DATA_W-1:0] measured_pin;
        logic signed [DATA_W-1:0] gain;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_freq_index;
        logic                     compressed;
        logic signed [DATA_W-1:0] max_gain;
        logic signed [DATA_W-1:0] pin_at_max_gain;
        logic signed [DATA_W-1:0] pout_at_max_gain;
        logic signed [DATA_W-1:0] pin_at_compression;
        logic signed [DATA_W-1:0] gain_at_compression;
        logic signed [DATA_W-1:0] pout_at_compression;
    } result_t;

    // one table entry, apart from the input power at compression
    typedef struct packed {
        logic signed [DATA_W-1:0] max_gain;
        logic signed [DATA_W-1:0] pin_at_max;
        logic                     compressed;
        logic signed [DATA_W-1:0] prev_pin;
        logic signed [DATA_W-1:0] prev_gain;
        logic signed [DATA_W-1:0] gain_at_comp;
    } entry_t;

    // how the input power at compression is settled
    typedef enum logic [1:0] {
        PC_NONE,
        PC_DIRECT,
        PC_INTERP,
        PC_HOLD
    } pc_mode_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        pc_mode_t                 mode;
        logic signed [DATA_W-1:0] base;
        logic                     neg;
        logic                     compressed;
        logic signed [DATA_W-1:0] max_gain;
        logic signed [DATA_W-1:0] pin_at_max;
        logic signed [DATA_W-1:0] gain_at_comp;
    } side_t;

    typedef struct packed {
        side_t                    side;
        logic signed [DATA_W-1:0] g0;
        logic signed [DATA_W-1:0] p1;
        logic signed [DATA_W-1:0] g1;
        logic signed [DATA_W-1:0] t;
    } interp_req_t;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (v < -34'sd32768)
        begin
            return 16'sh8000;
        end
        else
        begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

### src/gcpt_state.sv
module gcpt_state #(
    parameter int FREQ_POINTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  gcpt_pkg::in_item_t                  item,
    input  logic [gcpt_pkg::LEVEL_W-1:0]        level,
    input  logic                                expansion,
    output logic                                busy,
    output logic                                req_valid,
    output gcpt_pkg::interp_req_t               req
);

    localparam int ADDR_W = $clog2(FREQ_POINTS);

    gcpt_pkg::entry_t   mem [FREQ_POINTS];
    gcpt_pkg::entry_t   rd_entry;

    logic               s1_valid_reg;
    gcpt_pkg::in_item_t s1_item_reg;
    logic               s1_in_range_reg;

    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    gcpt_pkg::entry_t   fwd_entry_reg;

    logic               clr_active_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;

    logic               accept;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  s1_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    gcpt_pkg::entry_t   wr_data;

    gcpt_pkg::entry_t   cur;
    gcpt_pkg::entry_t   new_entry;
    logic signed [gcpt_pkg::DATA_W-1:0] pin;
    logic signed [gcpt_pkg::DATA_W-1:0] g;
    logic signed [gcpt_pkg::DATA_W-1:0] m;
    logic signed [gcpt_pkg::DATA_W-1:0] pm;
    logic signed [gcpt_pkg::DATA_W-1:0] target;
    logic signed [gcpt_pkg::DATA_W+1:0] diff;
    logic               flag;
    gcpt_pkg::pc_mode_t mode;
    logic signed [gcpt_pkg::DATA_W-1:0] base;

    assign busy    = clr_active_reg;
    assign accept  = start && !clr_active_reg;
    assign rd_addr = ADDR_W'(item.freq_index);
    assign s1_addr = ADDR_W'(s1_item_reg.freq_index);

    assign wr_en   = clr_active_reg || (s1_valid_reg && s1_in_range_reg);
    assign wr_addr = clr_active_reg ? clr_cnt_reg : s1_addr;
    assign wr_data = clr_active_reg ? '0 : new_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_entry <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg && s1_in_range_reg;
            if (clr_active_reg)
            begin
                if (clr_cnt_reg == ADDR_W'(FREQ_POINTS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg     <= item;
        s1_in_range_reg <= (32'(item.freq_index) < FREQ_POINTS);
        fwd_addr_reg    <= s1_addr;
        fwd_entry_reg   <= new_entry;
    end

    always_comb
    begin
        // take the entry written in the previous cycle, the memory still reads old data
        cur  = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_entry_reg : rd_entry;
        pin  = s1_item_reg.measured_pin;
        g    = s1_item_reg.gain;
        m    = cur.max_gain;
        pm   = cur.pin_at_max;
        flag = cur.compressed;
        if (expansion && (m < g))
        begin
            m    = g;
            pm   = pin;
            flag = 1'b0;
        end
        diff   = $signed({{2{m[gcpt_pkg::DATA_W-1]}}, m}) - $signed({5'd0, level});
        target = gcpt_pkg::sat16(34'(diff));

        new_entry           = cur;
        new_entry.prev_pin  = pin;
        new_entry.prev_gain = g;
        mode                = gcpt_pkg::PC_HOLD;
        base                = pin;

        if (s1_item_reg.first_sweep)
        begin
            new_entry.max_gain     = g;
            new_entry.pin_at_max   = pin;
            new_entry.compressed   = 1'b0;
            new_entry.gain_at_comp = g;
            mode                   = gcpt_pkg::PC_DIRECT;
        end
        else
        begin
            new_entry.max_gain   = m;
            new_entry.pin_at_max = pm;
            if (!flag)
            begin
                if (g <= target)
                begin
                    flag                   = 1'b1;
                    new_entry.gain_at_comp = target;
                    // equal gains: keep the current power
                    if (g == cur.prev_gain)
                    begin
                        mode = gcpt_pkg::PC_DIRECT;
                    end
                    else
                    begin
                        mode = gcpt_pkg::PC_INTERP;
                        base = cur.prev_pin;
                    end
                end
                else
                begin
                    new_entry.gain_at_comp = g;
                    mode                   = gcpt_pkg::PC_DIRECT;
                end
            end
            new_entry.compressed = flag;
        end

        req.side.idx          = s1_item_reg.freq_index;
        req.side.mode         = mode;
        req.side.base         = base;
        req.side.neg          = 1'b0;
        req.side.compressed   = new_entry.compressed;
        req.side.max_gain     = new_entry.max_gain;
        req.side.pin_at_max   = new_entry.pin_at_max;
        req.side.gain_at_comp = new_entry.gain_at_comp;
        req.g0                = cur.prev_gain;
        req.p1                = pin;
        req.g1                = g;
        req.t                 = target;
        if (!s1_in_range_reg)
        begin
            req.side.mode         = gcpt_pkg::PC_NONE;
            req.side.base         = '0;
            req.side.compressed   = 1'b0;
            req.side.max_gain     = '0;
            req.side.pin_at_max   = '0;
            req.side.gain_at_comp = '0;
        end
    end

    assign req_valid = s1_valid_reg;

endmodule

### src/gcpt_interp.sv
module gcpt_interp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  gcpt_pkg::interp_req_t               req,
    output logic                                fin_valid,
    output gcpt_pkg::side_t                     fin_side,
    output logic signed [gcpt_pkg::DATA_W-1:0]  fin_pin
);

    localparam int DW = gcpt_pkg::DATA_W;
    localparam int NB = gcpt_pkg::DIV_BITS;

    logic                 r2_valid_reg;
    gcpt_pkg::side_t      r2_side_reg;
    logic signed [DW:0]   r2_a_reg;
    logic signed [DW:0]   r2_b_reg;
    logic signed [DW:0]   r2_den_reg;

    logic                 r3_valid_reg;
    gcpt_pkg::side_t      r3_side_reg;
    logic signed [2*DW+1:0] r3_prod_reg;
    logic signed [DW:0]   r3_den_reg;

    logic signed [2*DW+1:0] prod_mag;
    logic signed [DW:0]     den_mag;
    gcpt_pkg::side_t        side0;

    logic [NB:0]          st_valid_reg;
    gcpt_pkg::side_t      st_side_reg [NB+1];
    logic [NB-1:0]        st_n_reg    [NB+1];
    logic [DW-1:0]        st_r_reg    [NB+1];
    logic [DW-1:0]        st_d_reg    [NB+1];

    logic                 fin_valid_reg;
    gcpt_pkg::side_t      fin_side_reg;
    logic signed [DW-1:0] fin_pin_reg;

    logic signed [2*DW+1:0] quot;
    logic signed [2*DW+1:0] sum;

    always_ff @(posedge clk)
    begin
        r2_side_reg <= req.side;
        r2_a_reg    <= $signed({req.t[DW-1], req.t}) - $signed({req.g0[DW-1], req.g0});
        r2_b_reg    <= $signed({req.p1[DW-1], req.p1})
                       - $signed({req.side.base[DW-1], req.side.base});
        r2_den_reg  <= $signed({req.g1[DW-1], req.g1}) - $signed({req.g0[DW-1], req.g0});

        r3_side_reg <= r2_side_reg;
        r3_prod_reg <= r2_a_reg * r2_b_reg;
        r3_den_reg  <= r2_den_reg;
    end

    assign prod_mag = r3_prod_reg[2*DW+1] ? -r3_prod_reg : r3_prod_reg;
    assign den_mag  = r3_den_reg[DW] ? -r3_den_reg : r3_den_reg;

    always_comb
    begin
        side0     = r3_side_reg;
        side0.neg = r3_prod_reg[2*DW+1] ^ r3_den_reg[DW];
    end

    always_ff @(posedge clk)
    begin
        st_side_reg[0]     <= side0;
        st_n_reg[0]        <= prod_mag[NB-1:0];
        st_r_reg[0]        <= '0;
        st_d_reg[0]        <= den_mag[DW-1:0];
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < NB; j++)
    begin : g_div
        logic [DW:0] trial;
        logic        ge;

        assign trial = {st_r_reg[j], st_n_reg[j][NB-1]};
        assign ge    = (trial >= {1'b0, st_d_reg[j]});

        always_ff @(posedge clk)
        begin
            st_side_reg[j+1] <= st_side_reg[j];
            st_d_reg[j+1]    <= st_d_reg[j];
            st_n_reg[j+1]    <= {st_n_reg[j][NB-2:0], ge};
            st_r_reg[j+1]    <= ge ? DW'(trial - {1'b0, st_d_reg[j]}) : trial[DW-1:0];
        end
    end

    always_comb
    begin
        quot = st_side_reg[NB].neg ? -$signed({2'b00, st_n_reg[NB]})
                                   : $signed({2'b00, st_n_reg[NB]});
        sum  = (2*DW+2)'(st_side_reg[NB].base) + quot;
    end

    always_ff @(posedge clk)
    begin
        fin_side_reg <= st_side_reg[NB];
        fin_pin_reg  <= (st_side_reg[NB].mode == gcpt_pkg::PC_INTERP)
                        ? gcpt_pkg::sat16(sum) : st_side_reg[NB].base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_valid_reg  <= 1'b0;
            r3_valid_reg  <= 1'b0;
            st_valid_reg  <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            r2_valid_reg  <= req_valid;
            r3_valid_reg  <= r2_valid_reg;
            st_valid_reg  <= {st_valid_reg[NB-1:0], r3_valid_reg};
            fin_valid_reg <= st_valid_reg[NB];
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_side  = fin_side_reg;
    assign fin_pin   = fin_pin_reg;

endmodule

### src/gcpt_commit.sv
module gcpt_commit #(
    parameter int FREQ_POINTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fin_valid,
    input  gcpt_pkg::side_t                     fin_side,
    input  logic signed [gcpt_pkg::DATA_W-1:0]  fin_pin,
    output logic                                done,
    output gcpt_pkg::result_t                   result
);

    localparam int ADDR_W = $clog2(FREQ_POINTS);
    localparam int DW     = gcpt_pkg::DATA_W;

    logic signed [DW-1:0] mem [FREQ_POINTS];
    logic signed [DW-1:0] rd_pin;

    logic                 e_valid_reg;
    gcpt_pkg::side_t      e_side_reg;
    logic signed [DW-1:0] e_pin_reg;

    logic                 fwd_valid_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    logic signed [DW-1:0] fwd_pin_reg;

    logic                 done_reg;
    gcpt_pkg::result_t    result_reg;

    logic [ADDR_W-1:0]    e_addr;
    logic                 e_live;
    logic signed [DW-1:0] pin_comp;
    logic                 wr_en;

    assign e_addr = ADDR_W'(e_side_reg.idx);
    assign e_live = e_valid_reg && (e_side_reg.mode != gcpt_pkg::PC_NONE);
    assign wr_en  = e_live && (e_side_reg.mode != gcpt_pkg::PC_HOLD);

    always_comb
    begin
        case (e_side_reg.mode)
            gcpt_pkg::PC_HOLD:
            begin
                pin_comp = (fwd_valid_reg && fwd_addr_reg == e_addr) ? fwd_pin_reg : rd_pin;
            end
            gcpt_pkg::PC_NONE:
            begin
                pin_comp = '0;
            end
            default:
            begin
                pin_comp = e_pin_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[e_addr] <= pin_comp;
        end
        rd_pin <= mem[ADDR_W'(fin_side.idx)];
    end

    always_ff @(posedge clk)
    begin
        e_side_reg   <= fin_side;
        e_pin_reg    <= fin_pin;
        fwd_addr_reg <= e_addr;
        fwd_pin_reg  <= pin_comp;

        result_reg.out_freq_index      <= e_side_reg.idx;
        result_reg.compressed          <= e_side_reg.compressed;
        result_reg.max_gain            <= e_side_reg.max_gain;
        result_reg.pin_at_max_gain     <= e_side_reg.pin_at_max;
        result_reg.pout_at_max_gain    <= gcpt_pkg::sat16(34'(e_side_reg.pin_at_max)
                                                          + 34'(e_side_reg.max_gain));
        result_reg.pin_at_compression  <= pin_comp;
        result_reg.gain_at_compression <= e_side_reg.gain_at_comp;
        result_reg.pout_at_compression <= gcpt_pkg::sat16(34'(pin_comp)
                                                          + 34'(e_side_reg.gain_at_comp));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            e_valid_reg   <= fin_valid;
            fwd_valid_reg <= e_live;
            done_reg      <= e_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/gain_compression_point_tracker.sv
// Takes one measured point per clock when start is high and busy is low, and
// delivers its result on result with done high for exactly one cycle, in
// acceptance order; the receiver cannot hold results off, so it must take
// every result as it appears. The rate of one item per cycle is set by the
// read-modify-write of the entry memory with forwarding of the entry written
// in the cycle before; the latency is set mainly by the 32-stage pipelined
// divider used for the interpolation. After reset busy stays high while a
// clearing pass zeroes every entry, compressed marks included.
// Write configuration only while no item is in flight.
module gain_compression_point_tracker #(
    parameter int FREQ_POINTS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  gcpt_pkg::in_item_t                   item,
    output logic                                 done,
    output gcpt_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [gcpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gcpt_pkg::LEVEL_W-1:0]         cfg_data
);

    localparam int LAT = gcpt_pkg::DIV_BITS + 7;

    logic [gcpt_pkg::LEVEL_W-1:0] level_reg;
    logic                         expansion_reg;

    logic                   req_valid;
    gcpt_pkg::interp_req_t  req;
    logic                   fin_valid;
    gcpt_pkg::side_t        fin_side;
    logic signed [gcpt_pkg::DATA_W-1:0] fin_pin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= gcpt_pkg::LEVEL_RESET;
            expansion_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gcpt_pkg::CFG_LEVEL:
                begin
                    level_reg <= cfg_data;
                end
                gcpt_pkg::CFG_EXPANSION:
                begin
                    expansion_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    gcpt_state #(
        .FREQ_POINTS(FREQ_POINTS)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .level     (level_reg),
        .expansion (expansion_reg),
        .busy      (busy),
        .req_valid (req_valid),
        .req       (req)
    );

    gcpt_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .fin_valid (fin_valid),
        .fin_side  (fin_side),
        .fin_pin   (fin_pin)
    );

    gcpt_commit #(
        .FREQ_POINTS(FREQ_POINTS)
    ) u_commit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_side  (fin_side),
        .fin_pin   (fin_pin),
        .done      (done),
        .result    (result)
    );

    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        busy |-> !done
    ) else $error("result delivered during clearing pass");

    a_fixed_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done
    ) else $error("accepted item gave no result at the fixed latency");

    a_out_of_range_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (32'(result.out_freq_index) >= FREQ_POINTS)) |->
            (!result.compressed && result.max_gain == '0 &&
             result.pin_at_compression == '0 && result.pout_at_compression == '0)
    ) else $error("out-of-range item returned non-zero fields");

endmodule

### tb/gain_compression_point_tracker_tb.sv
module gain_compression_point_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS       = 1024;
    localparam int LATENCY    = 39;
    localparam int CYCLE_CAP  = 400000;
    localparam int NSLOTS     = 8;
    localparam int PHASE_ITEMS = 108;
    localparam int DW         = gcpt_pkg::DATA_W;
    localparam int LW         = gcpt_pkg::LEVEL_W;
    localparam int CW         = gcpt_pkg::CFG_IDX_W;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CW-1:0]         cidx;
        logic [LW-1:0]         cdata;
        gcpt_pkg::in_item_t    it;
        bit                    typed;
        gcpt_pkg::result_t     res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    gcpt_pkg::in_item_t item = '0;
    logic done;
    gcpt_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [CW-1:0] cfg_index = '0;
    logic [LW-1:0] cfg_data = '0;

    gain_compression_point_tracker uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [LW-1:0]             p_level;
    logic                      p_expand;
    logic signed [DW-1:0]      t_max_gain [NPTS];
    logic signed [DW-1:0]      t_pin_max [NPTS];
    logic                      t_comp [NPTS];
    logic signed [DW-1:0]      t_prev_pin [NPTS];
    logic signed [DW-1:0]      t_prev_gain [NPTS];
    logic signed [DW-1:0]      t_pin_comp [NPTS];
    logic signed [DW-1:0]      t_gain_comp [NPTS];
    bit                        seeded [NPTS];

    gcpt_pkg::result_t pending_results [$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;

    function automatic logic signed [DW-1:0] clamp16(longint v);
        if (v > 32767)
        begin
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] interp_pin(longint p0, longint g0,
                                                       longint p1, longint g1,
                                                       longint t);
        longint den;
        den = g1 - g0;
        if (den == 0)
        begin
            return p1[DW-1:0];
        end
        return clamp16(p0 + ((t - g0) * (p1 - p0)) / den);
    endfunction

    function automatic gcpt_pkg::result_t track_point(gcpt_pkg::in_item_t x);
        gcpt_pkg::result_t r;
        int i;
        logic signed [DW-1:0] target;
        i = x.freq_index;
        if (x.first_sweep)
        begin
            t_max_gain[i] = x.gain;
            t_pin_max[i] = x.measured_pin;
            t_pin_comp[i] = x.measured_pin;
            t_gain_comp[i] = x.gain;
            t_comp[i] = 1'b0;
            seeded[i] = 1'b1;
        end
        else
        begin
            if (p_expand && t_max_gain[i] < x.gain)
            begin
                t_max_gain[i] = x.gain;
                t_pin_max[i] = x.measured_pin;
                t_comp[i] = 1'b0;
            end
            target = clamp16(longint'(t_max_gain[i]) - longint'(p_level));
            if (!t_comp[i])
            begin
                if (x.gain <= target)
                begin
                    t_pin_comp[i] = interp_pin(t_prev_pin[i], t_prev_gain[i],
                                               x.measured_pin, x.gain, target);
                    t_gain_comp[i] = target;
                    t_comp[i] = 1'b1;
                end
                else
                begin
                    t_pin_comp[i] = x.measured_pin;
                    t_gain_comp[i] = x.gain;
                end
            end
        end
        t_prev_pin[i] = x.measured_pin;
        t_prev_gain[i] = x.gain;
        r.out_freq_index = x.freq_index;
        r.compressed = t_comp[i];
        r.max_gain = t_max_gain[i];
        r.pin_at_max_gain = t_pin_max[i];
        r.pout_at_max_gain = clamp16(longint'(t_pin_max[i]) + longint'(t_max_gain[i]));
        r.pin_at_compression = t_pin_comp[i];
        r.gain_at_compression = t_gain_comp[i];
        r.pout_at_compression = clamp16(longint'(t_pin_comp[i])
                                        + longint'(t_gain_comp[i]));
        return r;
    endfunction

    task automatic check_field(string name, logic [DW-1:0] exp_v,
                               logic [DW-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name,
                     $signed(exp_v), $signed(act_v));
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        gcpt_pkg::result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result for index %0d", $realtime,
                         result.out_freq_index);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("out_freq_index", 16'(e.out_freq_index),
                            16'(result.out_freq_index));
                check_field("compressed", 16'(e.compressed), 16'(result.compressed));
                check_field("max_gain", e.max_gain, result.max_gain);
                check_field("pin_at_max_gain", e.pin_at_max_gain, result.pin_at_max_gain);
                check_field("pout_at_max_gain", e.pout_at_max_gain,
                            result.pout_at_max_gain);
                check_field("pin_at_compression", e.pin_at_compression,
                            result.pin_at_compression);
                check_field("gain_at_compression", e.gain_at_compression,
                            result.gain_at_compression);
                check_field("pout_at_compression", e.pout_at_compression,
                            result.pout_at_compression);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("gain_compression_point_tracker_tb: done, errors");
            $finish;
        end
    end

    // drive one item and hold it until accepted; typed rows override the prediction
    task automatic send_item(gcpt_pkg::in_item_t x, bit typed,
                             gcpt_pkg::result_t typed_res);
        gcpt_pkg::result_t r;
        int gap;
        @(negedge clk);
        start = 1'b1;
        item = x;
        do @(posedge clk); while (busy);
        r = track_point(x);
        pending_results.push_back(typed ? typed_res : r);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(4, 1);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (LATENCY + 6) @(negedge clk);
    endtask

    task automatic write_reg(logic [CW-1:0] idx, logic [LW-1:0] data);
        wait_drained();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == gcpt_pkg::CFG_LEVEL)
        begin
            p_level = data;
        end
        else
        begin
            p_expand = data[0];
        end
    endtask

    function automatic gcpt_pkg::in_item_t mk(bit f, int idx, int pin, int g);
        gcpt_pkg::in_item_t x;
        x.first_sweep = f;
        x.freq_index = idx[gcpt_pkg::IDX_W-1:0];
        x.measured_pin = pin[DW-1:0];
        x.gain = g[DW-1:0];
        return x;
    endfunction

    function automatic row_t blank_row();
        row_t w;
        w.kind = ROW_ITEM;
        w.cidx = '0;
        w.cdata = '0;
        w.it = '0;
        w.typed = 1'b0;
        w.res = '0;
        return w;
    endfunction

    function automatic row_t item_row(bit f, int idx, int pin, int g);
        row_t w;
        w = blank_row();
        w.kind = ROW_ITEM;
        w.it = mk(f, idx, pin, g);
        return w;
    endfunction

    function automatic row_t seed_row(int idx, int v);
        row_t w;
        w = item_row(1'b1, idx, v, v);
        w.typed = 1'b1;
        w.res = '{out_freq_index: idx[gcpt_pkg::IDX_W-1:0], compressed: 1'b0,
                  max_gain: v[15:0], pin_at_max_gain: v[15:0],
                  pout_at_max_gain: v[15:0], pin_at_compression: v[15:0],
                  gain_at_compression: v[15:0], pout_at_compression: v[15:0]};
        return w;
    endfunction

    function automatic row_t cfg_row(logic [CW-1:0] idx, int data);
        row_t w;
        w = blank_row();
        w.kind = ROW_CFG;
        w.cidx = idx;
        w.cdata = data[LW-1:0];
        return w;
    endfunction

    // interleaved sweeps, one per slot
    int slot_idx [NSLOTS];
    int slot_pin [NSLOTS];
    int slot_gain [NSLOTS];
    int slot_left [NSLOTS];

    function automatic int pick_idx();
        int v;
        v = $urandom_range(9) < 7 ? $urandom_range(31) : $urandom_range(NPTS - 1);
        return v;
    endfunction

    task automatic random_item();
        int s;
        int idx;
        gcpt_pkg::in_item_t x;
        int kind;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // noise: fully random seeding point
            x = mk(1'b1, $urandom_range(NPTS - 1), $urandom, $urandom);
        end
        else if (kind < 15)
        begin
            // noise: fully random point, a later one if its entry is seeded
            idx = pick_idx();
            x = mk(seeded[idx] ? 1'b0 : 1'b1, idx, $urandom, $urandom);
        end
        else
        begin
            s = $urandom_range(NSLOTS - 1);
            if (slot_left[s] == 0)
            begin
                slot_idx[s] = pick_idx();
                slot_pin[s] = int'($urandom_range(8000)) - 12000;
                slot_gain[s] = int'($urandom_range(10000)) - 2000;
                slot_left[s] = $urandom_range(20, 3);
                x = mk(1'b1, slot_idx[s], slot_pin[s], slot_gain[s]);
            end
            else
            begin
                slot_pin[s] += $urandom_range(512, 32);
                if ($urandom_range(9) == 0)
                begin
                    slot_gain[s] += $urandom_range(400);
                end
                else
                begin
                    slot_gain[s] -= $urandom_range(160);
                end
                slot_pin[s] = clamp16(slot_pin[s]);
                slot_gain[s] = clamp16(slot_gain[s]);
                slot_left[s]--;
                x = mk(seeded[slot_idx[s]] ? 1'b0 : 1'b1, slot_idx[s],
                       slot_pin[s], slot_gain[s]);
            end
        end
        send_item(x, 1'b0, '0);
    endtask

    initial
    begin
        row_t rows [$];
        int levels [6];
        int lv;
        p_level = gcpt_pkg::LEVEL_RESET;
        p_expand = 1'b0;
        foreach (t_comp[i])
        begin
            t_comp[i] = 1'b0;
            seeded[i] = 1'b0;
            t_max_gain[i] = '0;
            t_pin_max[i] = '0;
            t_prev_pin[i] = '0;
            t_prev_gain[i] = '0;
            t_pin_comp[i] = '0;
            t_gain_comp[i] = '0;
        end
        foreach (slot_left[s])
        begin
            slot_left[s] = 0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // extremes, crossing, hold, equal gains, expansion reset
        rows.push_back(seed_row(0, 32767));
        rows.push_back(seed_row(1023, -32768));
        rows.push_back(item_row(1'b0, 0, 0, 32767));
        rows.push_back(item_row(1'b0, 0, 256, -32768));
        rows.push_back(item_row(1'b0, 0, 512, 32767));
        rows.push_back(item_row(1'b0, 1023, 32767, -32768));
        rows.push_back(item_row(1'b1, 5, -2560, 5120));
        rows.push_back(item_row(1'b0, 5, -2048, 5000));
        rows.push_back(item_row(1'b0, 5, -1536, 4700));
        rows.push_back(item_row(1'b0, 5, -1024, 3000));
        rows.push_back(item_row(1'b0, 5, -512, 6000));
        rows.push_back(cfg_row(gcpt_pkg::CFG_LEVEL, 0));
        rows.push_back(item_row(1'b1, 7, 100, 100));
        rows.push_back(item_row(1'b0, 7, 300, 100));
        rows.push_back(cfg_row(gcpt_pkg::CFG_LEVEL, 8191));
        rows.push_back(item_row(1'b1, 8, 1000, -30000));
        rows.push_back(item_row(1'b0, 8, 1100, -32000));
        rows.push_back(cfg_row(gcpt_pkg::CFG_EXPANSION, 1));
        rows.push_back(cfg_row(gcpt_pkg::CFG_LEVEL, 256));
        rows.push_back(item_row(1'b0, 5, 0, 7000));
        rows.push_back(item_row(1'b0, 5, 256, 6800));
        rows.push_back(item_row(1'b0, 5, 512, 6600));
        rows.push_back(item_row(1'b0, 5, 768, 7200));
        rows.push_back(item_row(1'b0, 0, -32768, 32767));
        foreach (rows[k])
        begin
            if (rows[k].kind == ROW_CFG)
            begin
                write_reg(rows[k].cidx, rows[k].cdata);
            end
            else
            begin
                send_item(rows[k].it, rows[k].typed, rows[k].res);
            end
        end

        levels = '{256, 0, 8191, 64, 1024, 0};
        for (int ph = 0; ph < 6; ph++)
        begin
            lv = (ph == 5) ? int'($urandom_range(8191)) : levels[ph];
            write_reg(gcpt_pkg::CFG_LEVEL, lv[LW-1:0]);
            write_reg(gcpt_pkg::CFG_EXPANSION, LW'(ph % 2));
            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 48 : 32;
            repeat (PHASE_ITEMS) random_item();
        end

        wait_drained();
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("gain_compression_point_tracker_tb: done, clean");
        end
        else
        begin
            $display("gain_compression_point_tracker_tb: done, errors");
        end
        $finish;
    end

endmodule
